/* rtl/pol_pkg.sv */
// ----------------------------------------------------------------------------
// pol_pkg: shared types for the positional ordered list
// Command codes, control state and the per-cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package pol_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_FIND   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORK,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_LOAD,
    SEL_LEFT,
    SEL_RIGHT
  } sel_t;

  typedef struct packed {
    sel_t sel;
    logic active;
  } cell_ctl_t;

  localparam int DataW  = 32;
  localparam int PosW   = 5;
  localparam int FoundW = 6;
  localparam int LenW   = 5;

endpackage

`default_nettype wire

/* rtl/pol_cell.sv */
// ----------------------------------------------------------------------------
// pol_cell: one storage cell of the list chain
// Holds one entry, loads a new value or takes a neighbor's entry on a shift,
// and compares its entry against the search key.
// ----------------------------------------------------------------------------
`default_nettype none

module pol_cell (
  input  wire logic                     clk,
  input  wire pol_pkg::cell_ctl_t       ctl,
  input  wire logic [pol_pkg::DataW-1:0] load_value,
  input  wire logic [pol_pkg::DataW-1:0] left_entry,
  input  wire logic [pol_pkg::DataW-1:0] right_entry,
  input  wire logic [pol_pkg::DataW-1:0] key,
  output logic      [pol_pkg::DataW-1:0] entry,
  output logic                           hit
);
  import pol_pkg::*;

  always_ff @(posedge clk) begin
    unique case (ctl.sel)
      SEL_HOLD:  entry <= entry;
      SEL_LOAD:  entry <= load_value;
      SEL_LEFT:  entry <= left_entry;
      SEL_RIGHT: entry <= right_entry;
      default:   entry <= entry;
    endcase
  end

  assign hit = ctl.active && (entry == key);

endmodule

`default_nettype wire

/* rtl/positional_ordered_list.sv */
// ----------------------------------------------------------------------------
// positional_ordered_list: bounded list with positional insert/remove/get/find
// Top level: request capture, control sequencer, cell chain and result register.
// ----------------------------------------------------------------------------
// The list lives in a chain of CAPACITY cells. Insert shifts the cells at and
// after the position one step toward the tail and loads the new value; remove
// shifts them one step toward the head; get selects one cell; find compares
// every cell in parallel and picks the first hit. One request is in flight at
// a time: the cell chain updates and the result register loads in ST_WORK,
// and the result is then held valid in ST_DONE until it is taken. With
// out_ready held high the next request is accepted in the same cycle its
// predecessor's result is taken.
`default_nettype none

module positional_ordered_list #(
  parameter int CAPACITY = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       command,
  input  wire logic [pol_pkg::PosW-1:0]         position,
  input  wire logic signed [pol_pkg::DataW-1:0] value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  ok,
  output logic signed [pol_pkg::DataW-1:0]      read_value,
  output logic signed [pol_pkg::FoundW-1:0]     found_position,
  output logic [pol_pkg::LenW-1:0]              list_length
);
  import pol_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int EW = ((CW > PosW) ? CW : PosW) + 1;

  state_t state, state_next;
  logic   take_req;
  logic   do_work;

  cmd_t             cmd_q;
  logic [PosW-1:0]  pos_q;
  logic [DataW-1:0] val_q;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;

  logic [EW-1:0] pos_e;
  logic [EW-1:0] cnt_e;
  logic [EW-1:0] k;
  logic          ins_ok;
  logic          rem_ok;
  logic          get_ok;

  logic [DataW-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0] hit;
  cell_ctl_t           ctl [CAPACITY];

  logic [IW-1:0] fidx;
  logic          any_hit;
  logic [IW:0]   fnum;

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    do_work    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_WORK;
        end
      end
      ST_WORK: begin
        do_work    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
        if (out_ready) begin
          state_next = in_valid ? ST_WORK : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign take_req = in_valid && in_ready;

  // Request capture
  always_ff @(posedge clk) begin
    if (take_req) begin
      cmd_q <= cmd_t'(command);
      pos_q <= position;
      val_q <= value;
    end
  end

  // Range checks
  assign pos_e  = EW'(pos_q);
  assign cnt_e  = EW'(count);
  assign k      = pos_e - EW'(1);
  assign ins_ok = (cmd_q == CMD_INSERT) && (pos_q != '0) && (pos_e <= cnt_e + EW'(1))
                  && (cnt_e < EW'(CAPACITY));
  assign rem_ok = (cmd_q == CMD_REMOVE) && (pos_q != '0) && (pos_e <= cnt_e);
  assign get_ok = (cmd_q == CMD_GET) && (pos_q != '0) && (pos_e <= cnt_e);

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DataW-1:0] left_entry;
    logic [DataW-1:0] right_entry;

    always_comb begin
      ctl[i].active = (EW'(i) < cnt_e);
      ctl[i].sel    = SEL_HOLD;
      if (do_work && ins_ok) begin
        if (EW'(i) == k) begin
          ctl[i].sel = SEL_LOAD;
        end else if (EW'(i) > k) begin
          ctl[i].sel = SEL_LEFT;
        end
      end else if (do_work && rem_ok && (EW'(i) >= k)) begin
        ctl[i].sel = SEL_RIGHT;
      end
    end

    if (i == 0) begin : g_head
      assign left_entry = val_q;
    end else begin : g_body
      assign left_entry = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = entry[i];
    end else begin : g_inner
      assign right_entry = entry[i+1];
    end

    pol_cell u_cell (
      .clk         (clk),
      .ctl         (ctl[i]),
      .load_value  (val_q),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .key         (val_q),
      .entry       (entry[i]),
      .hit         (hit[i])
    );
  end

  // First hit
  always_comb begin
    fidx    = '0;
    any_hit = |hit;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hit[i]) begin
        fidx = IW'(i);
      end
    end
  end

  assign fnum = (IW + 1)'(fidx) + (IW + 1)'(1);

  // Length update
  always_comb begin
    count_next = count;
    if (ins_ok) begin
      count_next = count + CW'(1);
    end else if (rem_ok) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_work) begin
      count <= count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (do_work) begin
      list_length    <= LenW'(count_next);
      read_value     <= get_ok ? entry[k[IW-1:0]] : '0;
      found_position <= ((cmd_q == CMD_FIND) && any_hit) ? FoundW'(fnum) : '1;
      unique case (cmd_q)
        CMD_INSERT: ok <= ins_ok;
        CMD_REMOVE: ok <= rem_ok;
        CMD_GET:    ok <= get_ok;
        CMD_FIND:   ok <= any_hit;
        default:    ok <= 1'b0;
      endcase
    end
  end

endmodule

`default_nettype wire
